// File: src/saltc_pkg.sv
package saltc_pkg;

    // Address split
    localparam int ADDR_BITS   = 32;
    localparam int OFFSET_BITS = 5;
    localparam int SET_BITS    = 4;
    localparam int TAG_SHIFT   = 9;
    localparam int TAG_BITS    = ADDR_BITS - TAG_SHIFT;

    // Organization
    localparam int WAYS       = 4;
    localparam int WAY_BITS   = 2;
    localparam int SETS       = 1 << SET_BITS;
    localparam int LINE_BITS  = SET_BITS + WAY_BITS;
    localparam int LINES      = 1 << LINE_BITS;
    localparam int STAMP_BITS = 32;

    typedef logic [TAG_BITS-1:0]   tag_t;
    typedef logic [STAMP_BITS-1:0] stamp_t;
    typedef logic [SET_BITS-1:0]   set_t;
    typedef logic [WAY_BITS-1:0]   way_t;
    typedef logic [LINE_BITS-1:0]  line_idx_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    localparam way_t LAST_WAY = way_t'(WAYS - 1);

    // One line's metadata as held in the tag RAM
    typedef struct packed {
        tag_t   tag;
        logic   dirty;
        stamp_t stamp;
    } meta_t;

    localparam int META_BITS = $bits(meta_t);

    // Outcome of scanning the ways of one set
    typedef struct packed {
        logic hit;
        way_t hit_way;
        logic hit_dirty;
        logic inv;
        way_t inv_way;
        way_t min_way;
        tag_t min_tag;
        logic min_dirty;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

// File: src/saltc_ram.sv
module saltc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/saltc_way_scan.sv
module saltc_way_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              enable,
    input  saltc_pkg::way_t   way_idx,
    input  logic              entry_valid,
    input  saltc_pkg::meta_t  entry,
    input  saltc_pkg::tag_t   req_tag,
    output saltc_pkg::scan_t  result
);

    import saltc_pkg::*;

    logic   hit_reg;
    way_t   hit_way_reg;
    logic   hit_dirty_reg;
    logic   inv_reg;
    way_t   inv_way_reg;
    way_t   min_way_reg;
    tag_t   min_tag_reg;
    logic   min_dirty_reg;
    stamp_t min_stamp_reg;

    logic match;
    logic lower;

    // Shared compare unit: tag match and stamp order for one way per cycle
    assign match = entry_valid && (entry.tag == req_tag);
    assign lower = (way_idx == '0) || (entry.stamp < min_stamp_reg);

    // Track hit and first invalid way
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            hit_reg <= 1'b0;
            inv_reg <= 1'b0;
        end else if (enable) begin
            if (match && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (!entry_valid && !inv_reg) begin
                inv_reg <= 1'b1;
            end
        end
    end

    // Hold way payloads; strict compare keeps ties on the lower way
    always_ff @(posedge aclk) begin
        if (enable) begin
            if (match && !hit_reg) begin
                hit_way_reg   <= way_idx;
                hit_dirty_reg <= entry.dirty;
            end
            if (!entry_valid && !inv_reg) begin
                inv_way_reg <= way_idx;
            end
            if (entry_valid && lower) begin
                min_stamp_reg <= entry.stamp;
                min_way_reg   <= way_idx;
                min_tag_reg   <= entry.tag;
                min_dirty_reg <= entry.dirty;
            end
        end
    end

    assign result.hit       = hit_reg;
    assign result.hit_way   = hit_way_reg;
    assign result.hit_dirty = hit_dirty_reg;
    assign result.inv       = inv_reg;
    assign result.inv_way   = inv_way_reg;
    assign result.min_way   = min_way_reg;
    assign result.min_tag   = min_tag_reg;
    assign result.min_dirty = min_dirty_reg;

endmodule

// File: src/set_assoc_lru_tag_controller_core.sv
// Tag and LRU replacement controller for a 4-way, 16-set write-back cache.
// Input channel (s_*): one word per access, a byte address and a store flag.
// Result channel (m_*): one word per access, with hit, the hit or victim way,
// and, for a miss that evicts a valid dirty line, its line address.
// Each access passes through the acceptance cycle, a scan state in which
// the single tag/stamp RAM read port and one compare unit visit one way per
// cycle, and an update state that writes the new metadata back. The result
// word is registered in the update state; the next access is accepted once
// the controller is back in idle.
// s_ready is high only while the controller is idle. A finished result sits
// in an output register; a new access may be accepted while it waits, but
// its update cycle holds until the waiting result is taken, so a stalled
// receiver stalls the controller without losing or repeating a word.
// Reset (aresetn low, synchronous) clears all line valid bits, the per-set
// stamp counters and the result register; tags, dirty bits and stamps are
// only read for valid lines and need no clearing.
module set_assoc_lru_tag_controller_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  saltc_pkg::addr_t       s_address,
    input  logic                   s_store,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output saltc_pkg::way_t        m_way,
    output logic                   m_writeback_needed,
    output saltc_pkg::addr_t       m_writeback_address
);

    import saltc_pkg::*;

    state_t state_reg, state_next;

    addr_t  addr_reg;
    logic   wr_reg;
    way_t   way_reg;
    logic [LINES-1:0] valid_reg;
    stamp_t counter_reg [SETS];

    logic   out_valid_reg;
    logic   out_hit_reg;
    way_t   out_way_reg;
    logic   out_wb_reg;
    addr_t  out_wb_addr_reg;

    logic      accept;
    logic      scan_en;
    logic      commit;
    set_t      s_set;
    set_t      set_reg;
    tag_t      tag_reg;
    line_idx_t rd_addr;
    line_idx_t wr_addr;
    logic [META_BITS-1:0] rd_word;
    meta_t     rd_meta;
    meta_t     wr_meta;
    scan_t     scan;
    way_t      victim;
    logic      wb;
    addr_t     wb_addr;

    assign s_set   = s_address[OFFSET_BITS +: SET_BITS];
    assign set_reg = addr_reg[OFFSET_BITS +: SET_BITS];
    assign tag_reg = addr_reg[ADDR_BITS-1:TAG_SHIFT];
    assign accept  = s_valid && s_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (way_reg == LAST_WAY) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        scan_en = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_SCAN:   scan_en = 1'b1;
            ST_UPDATE: commit  = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Latch the access and step the way counter
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg <= s_address;
            wr_reg   <= s_store;
            way_reg  <= '0;
        end else if (scan_en) begin
            way_reg  <= way_t'(way_reg + 1'b1);
        end
    end

    // Read address: first way at acceptance, then the following way
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_addr = {s_set, way_t'(0)};
        end else begin
            rd_addr = {set_reg, way_t'(way_reg + 1'b1)};
        end
    end

    saltc_ram #(
        .WIDTH (META_BITS),
        .DEPTH (LINES)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (commit),
        .waddr (wr_addr),
        .wdata (wr_meta),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    assign rd_meta = meta_t'(rd_word);

    saltc_way_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (accept),
        .enable      (scan_en),
        .way_idx     (way_reg),
        .entry_valid (valid_reg[{set_reg, way_reg}]),
        .entry       (rd_meta),
        .req_tag     (tag_reg),
        .result      (scan)
    );

    // Pick the way to update and build the write-back address
    always_comb begin
        if (scan.hit) begin
            victim = scan.hit_way;
        end else if (scan.inv) begin
            victim = scan.inv_way;
        end else begin
            victim = scan.min_way;
        end
        wb = !scan.hit && !scan.inv && scan.min_dirty;
        if (wb) begin
            wb_addr = (addr_t'(scan.min_tag) << TAG_SHIFT) |
                      (addr_t'(set_reg) << OFFSET_BITS);
        end else begin
            wb_addr = '0;
        end
        wr_addr       = {set_reg, victim};
        wr_meta.tag   = tag_reg;
        wr_meta.dirty = scan.hit ? (scan.hit_dirty | wr_reg) : wr_reg;
        wr_meta.stamp = counter_reg[set_reg];
    end

    // Mark the line valid and advance the set counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SETS; i++) begin
                counter_reg[i] <= '0;
            end
        end else if (commit) begin
            valid_reg[wr_addr]   <= 1'b1;
            counter_reg[set_reg] <= stamp_t'(counter_reg[set_reg] + 1'b1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_hit_reg     <= scan.hit;
            out_way_reg     <= victim;
            out_wb_reg      <= wb;
            out_wb_addr_reg <= wb_addr;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_hit               = out_hit_reg;
    assign m_way               = out_way_reg;
    assign m_writeback_needed  = out_wb_reg;
    assign m_writeback_address = out_wb_addr_reg;

endmodule

// File: src/saltc_checker.sv
module saltc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_address,
    input logic        s_store,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [1:0]  m_way,
    input logic        m_writeback_needed,
    input logic [31:0] m_writeback_address
);

    // Leave reset idle with no result word
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> (s_ready && !m_valid))
        else $error("not idle after reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_hit) && $stable(m_way) &&
             $stable(m_writeback_needed) && $stable(m_writeback_address)))
        else $error("result word changed while stalled");

    // Busy right after an access is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second word back to back");

    // No result appears in the cycle after an access with nothing pending
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> !m_valid)
        else $error("result word appeared too early");

    // A write-back is only reported on a miss
    a_wb_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_writeback_needed) |-> !m_hit)
        else $error("write-back reported on a hit");

endmodule

bind set_assoc_lru_tag_controller_core saltc_checker u_saltc_checker (.*);
